// ===== rtl/lsgc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsgc_pkg
// Types, codes and constants shared by the slope ground classifier files.
// ----------------------------------------------------------------------------
package lsgc_pkg;

  localparam int AZIMUTH_BINS_DEF = 1024;
  localparam int RING_COUNT_DEF   = 64;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int SLOPE_W    = 24;

  // Stored ground point: valid mark on top, then z, y, x.
  localparam int ENTRY_W = 49;

  // Squared minimum planar distance for the noise-floor test (50 mm).
  localparam logic [32:0] MIN_PLANAR_SQ = 33'd2500;

  localparam logic [31:0] FRONT_X_RST  = 32'd3311991482;
  localparam logic [31:0] REAR_X_RST   = 32'd88488600;
  localparam logic [31:0] LAT_Y_RST    = 32'd3639617296;
  localparam logic [31:0] HEIGHT_Z_RST = 32'd4222880196;
  localparam logic [31:0] GROUND_RST   = 32'd68813050;
  localparam logic [31:0] STEP_RST     = 32'd13107300;
  localparam logic [23:0] SLOPE_RST    = 24'd2038;

  typedef enum logic [2:0] {
    REG_FRONT_X  = 3'd0,
    REG_REAR_X   = 3'd1,
    REG_LAT_Y    = 3'd2,
    REG_HEIGHT_Z = 3'd3,
    REG_GROUND   = 3'd4,
    REG_STEP     = 3'd5,
    REG_SLOPE    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_DROP      = 2'd0,
    CLS_GROUND    = 2'd1,
    CLS_NONGROUND = 2'd2
  } cls_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_T,
    ST_DECIDE,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/lsgc_ram.sv =====
// ----------------------------------------------------------------------------
// lsgc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsgc_ram #(
  parameter int WIDTH = lsgc_pkg::ENTRY_W,
  parameter int DEPTH = lsgc_pkg::AZIMUTH_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lidar_slope_ground_classifier.sv =====
// ----------------------------------------------------------------------------
// lidar_slope_ground_classifier
// Crops lidar points, sorts them into azimuth bins and marks each kept point
// as ground or nonground against the global level and its bin's last ground
// point, using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Content
//   in_      slave      in_tvalid / in_tready     one point (x, y, z, ring, az)
//   out_     master     out_tvalid / out_tready   class and azimuth bin
//   cfg_     APB slave  psel / penable / pready   six 32-bit, one 24-bit register
//
// A dropped point or one at the global ground level passes ST_EVAL and ST_FIN
// before the next in_tready; a point checked against its bin also goes
// through ST_DIFF, four passes through the shared 32x24 multiplier and ST_DECIDE.
// A point with the frame-start flag first runs a sweep through the bin RAM
// that clears all ground marks. Reset runs the same sweep before in_tready
// first rises. A finished result waits in the output register while the
// next point is taken; only a still-full output register holds the block.

module lidar_slope_ground_classifier #(
  parameter int AZIMUTH_BINS = lsgc_pkg::AZIMUTH_BINS_DEF,
  parameter int RING_COUNT   = lsgc_pkg::RING_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input points
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [71:0]                     in_tdata,  // x_mm, y_mm, z_mm, ring_index, azimuth
  input  logic [0:0]                      in_tuser,  // frame_start
  // Results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata, // bin_index, zero fill
  output logic [1:0]                      out_tuser, // point_class
  // Configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lsgc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lsgc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lsgc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int BIN_W  = $clog2(AZIMUTH_BINS);
  localparam int PROD_W = 16 + BIN_W;
  localparam logic [PROD_W-1:0] BINS_C   = PROD_W'(AZIMUTH_BINS);
  localparam logic [BIN_W-1:0]  BIN_LAST = BIN_W'(AZIMUTH_BINS - 1);
  localparam logic [8:0]        RING_LIM = 9'(RING_COUNT);

  // Configuration registers
  logic [31:0] front_x_r, rear_x_r, lat_y_r, height_z_r, ground_r, step_r;
  logic [lsgc_pkg::SLOPE_W-1:0] slope_r;
  logic                         cfg_wr;
  lsgc_pkg::reg_idx_t           cfg_idx;

  // Control
  lsgc_pkg::state_t state_r, state_nxt;
  logic [BIN_W-1:0] clr_cnt_r;
  logic             item_r;
  logic             out_tvalid_r;
  logic             fin_go;

  // Payload
  logic signed [15:0] x_r, y_r, z_r;
  logic [7:0]         ring_r;
  logic [15:0]        az_r;
  logic [BIN_W-1:0]   bin_r;
  lsgc_pkg::cls_t     cls_r;
  logic [15:0]        dx_r, dy_r, dz_r;
  logic [32:0]        acc_r;
  logic [31:0]        dz2_r;
  logic [56:0]        slope_prod_r;
  logic [1:0]         out_cls_r;
  logic [9:0]         out_bin_r;

  // Bin RAM port
  logic                             ram_we;
  logic [BIN_W-1:0]                 ram_waddr, ram_raddr;
  logic [lsgc_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;

  // Evaluation logic
  logic              x_ok, y_ok, z_ok, ring_ok, keep_c, glob_c;
  logic [PROD_W-1:0] bin_prod;
  logic [BIN_W-1:0]  bin_c;
  logic signed [17:0] lvl_sum;
  logic [16:0]        lvl_abs;
  logic signed [16:0] dx_c, dy_c, dz_c;
  logic [15:0]        sx, sy, sz;
  logic               slope_ok, noise_ok, ground_c;
  logic [11:0]        bin_ext;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = lsgc_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_x_r  <= lsgc_pkg::FRONT_X_RST;
      rear_x_r   <= lsgc_pkg::REAR_X_RST;
      lat_y_r    <= lsgc_pkg::LAT_Y_RST;
      height_z_r <= lsgc_pkg::HEIGHT_Z_RST;
      ground_r   <= lsgc_pkg::GROUND_RST;
      step_r     <= lsgc_pkg::STEP_RST;
      slope_r    <= lsgc_pkg::SLOPE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lsgc_pkg::REG_FRONT_X:  front_x_r  <= cfg_pwdata;
        lsgc_pkg::REG_REAR_X:   rear_x_r   <= cfg_pwdata;
        lsgc_pkg::REG_LAT_Y:    lat_y_r    <= cfg_pwdata;
        lsgc_pkg::REG_HEIGHT_Z: height_z_r <= cfg_pwdata;
        lsgc_pkg::REG_GROUND:   ground_r   <= cfg_pwdata;
        lsgc_pkg::REG_STEP:     step_r     <= cfg_pwdata;
        lsgc_pkg::REG_SLOPE:    slope_r    <= cfg_pwdata[lsgc_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lsgc_pkg::REG_FRONT_X:  cfg_prdata = front_x_r;
      lsgc_pkg::REG_REAR_X:   cfg_prdata = rear_x_r;
      lsgc_pkg::REG_LAT_Y:    cfg_prdata = lat_y_r;
      lsgc_pkg::REG_HEIGHT_Z: cfg_prdata = height_z_r;
      lsgc_pkg::REG_GROUND:   cfg_prdata = ground_r;
      lsgc_pkg::REG_STEP:     cfg_prdata = step_r;
      lsgc_pkg::REG_SLOPE:    cfg_prdata = 32'(slope_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Crop, bin and global level checks on the captured point
  // --------------------------------------------------------------------------
  always_comb begin
    x_ok = ($signed(front_x_r[31:16]) <= x_r && x_r <= $signed(front_x_r[15:0])) ||
           ($signed(rear_x_r[31:16]) <= x_r && x_r <= $signed(rear_x_r[15:0]));
    y_ok = $signed(lat_y_r[31:16]) <= y_r && y_r <= $signed(lat_y_r[15:0]);
    z_ok = $signed(height_z_r[31:16]) <= z_r && z_r <= $signed(height_z_r[15:0]);
    ring_ok = {1'b0, ring_r} < RING_LIM;
    keep_c  = x_ok && y_ok && z_ok && ring_ok;

    bin_prod = PROD_W'(az_r) * BINS_C;
    bin_c    = bin_prod[PROD_W-1:16];

    lvl_sum = 18'(z_r) + $signed({2'b00, ground_r[31:16]});
    lvl_abs = lvl_sum[17] ? 17'(-lvl_sum) : lvl_sum[16:0];
    glob_c  = lvl_abs < {1'b0, ground_r[15:0]};
  end

  // Signed distances to the bin's stored ground point; ST_DIFF registers their magnitudes.
  always_comb begin
    sx   = ram_rdata[15:0];
    sy   = ram_rdata[31:16];
    sz   = ram_rdata[47:32];
    dx_c = 17'(x_r) - $signed({sx[15], sx});
    dy_c = 17'(y_r) - $signed({sy[15], sy});
    dz_c = 17'(z_r) - $signed({sz[15], sz});
  end

  // Final decision once all products are in.
  always_comb begin
    slope_ok = {9'd0, dz2_r, 16'd0} < slope_prod_r;
    noise_ok = !(dz_r > step_r[31:16]) && dz_r < step_r[15:0] &&
               acc_r > lsgc_pkg::MIN_PLANAR_SQ;
    ground_c = slope_ok || noise_ok;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign fin_go = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsgc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == BIN_LAST) begin
          state_nxt = item_r ? lsgc_pkg::ST_EVAL : lsgc_pkg::ST_IDLE;
        end
      end
      lsgc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_tuser[0] ? lsgc_pkg::ST_CLEAR : lsgc_pkg::ST_EVAL;
        end
      end
      lsgc_pkg::ST_EVAL: begin
        state_nxt = (keep_c && !glob_c) ? lsgc_pkg::ST_DIFF : lsgc_pkg::ST_FIN;
      end
      lsgc_pkg::ST_DIFF: begin
        state_nxt = ram_rdata[48] ? lsgc_pkg::ST_MUL_X : lsgc_pkg::ST_FIN;
      end
      lsgc_pkg::ST_MUL_X:  state_nxt = lsgc_pkg::ST_MUL_Y;
      lsgc_pkg::ST_MUL_Y:  state_nxt = lsgc_pkg::ST_MUL_Z;
      lsgc_pkg::ST_MUL_Z:  state_nxt = lsgc_pkg::ST_MUL_T;
      lsgc_pkg::ST_MUL_T:  state_nxt = lsgc_pkg::ST_DECIDE;
      lsgc_pkg::ST_DECIDE: state_nxt = lsgc_pkg::ST_FIN;
      lsgc_pkg::ST_FIN: begin
        if (fin_go) begin
          state_nxt = lsgc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lsgc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = bin_r;
    ram_wdata = {1'b1, z_r, y_r, x_r};
    ram_raddr = bin_r;
    mul_a     = 32'(dx_r);
    mul_b     = 24'(dx_r);
    unique case (state_r)
      lsgc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      lsgc_pkg::ST_IDLE: in_tready = 1'b1;
      // Start the bin read right away so the entry is there in ST_DIFF.
      lsgc_pkg::ST_EVAL: ram_raddr = bin_c;
      lsgc_pkg::ST_MUL_Y: begin
        mul_a = 32'(dy_r);
        mul_b = 24'(dy_r);
      end
      lsgc_pkg::ST_MUL_Z: begin
        mul_a = 32'(dz_r);
        mul_b = 24'(dz_r);
      end
      lsgc_pkg::ST_MUL_T: begin
        mul_a = acc_r[31:0];
        mul_b = slope_r;
      end
      lsgc_pkg::ST_FIN: ram_we = fin_go && (cls_r == lsgc_pkg::CLS_GROUND);
      default: ;
    endcase
  end

  assign mul_p = 56'(mul_a) * 56'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lsgc_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      item_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lsgc_pkg::ST_CLEAR) begin
        clr_cnt_r <= (clr_cnt_r == BIN_LAST) ? '0 : clr_cnt_r + 1'b1;
      end
      if (in_tvalid && in_tready) begin
        item_r <= 1'b1;
      end else if (state_r == lsgc_pkg::ST_FIN && fin_go) begin
        item_r <= 1'b0;
      end
      if (state_r == lsgc_pkg::ST_FIN && fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  assign bin_ext = 12'(bin_r);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r    <= in_tdata[15:0];
      y_r    <= in_tdata[31:16];
      z_r    <= in_tdata[47:32];
      ring_r <= in_tdata[55:48];
      az_r   <= in_tdata[71:56];
    end
    unique case (state_r)
      lsgc_pkg::ST_EVAL: begin
        // A dropped point reports bin zero.
        bin_r <= keep_c ? bin_c : '0;
        if (!keep_c) begin
          cls_r <= lsgc_pkg::CLS_DROP;
        end else if (glob_c) begin
          cls_r <= lsgc_pkg::CLS_GROUND;
        end else begin
          cls_r <= lsgc_pkg::CLS_NONGROUND;
        end
      end
      lsgc_pkg::ST_DIFF: begin
        dx_r <= dx_c[16] ? 16'(-dx_c) : dx_c[15:0];
        dy_r <= dy_c[16] ? 16'(-dy_c) : dy_c[15:0];
        dz_r <= dz_c[16] ? 16'(-dz_c) : dz_c[15:0];
      end
      lsgc_pkg::ST_MUL_X: acc_r <= {1'b0, mul_p[31:0]};
      lsgc_pkg::ST_MUL_Y: acc_r <= acc_r + {1'b0, mul_p[31:0]};
      lsgc_pkg::ST_MUL_Z: dz2_r <= mul_p[31:0];
      lsgc_pkg::ST_MUL_T: begin
        // The 33rd bit of the planar distance adds the tangent shifted by 32.
        slope_prod_r <= 57'(mul_p) + (acc_r[32] ? {1'b0, slope_r, 32'd0} : 57'd0);
      end
      lsgc_pkg::ST_DECIDE: begin
        cls_r <= ground_c ? lsgc_pkg::CLS_GROUND : lsgc_pkg::CLS_NONGROUND;
      end
      default: ;
    endcase
    if (state_r == lsgc_pkg::ST_FIN && fin_go) begin
      out_cls_r <= cls_r;
      out_bin_r <= bin_ext[9:0];
    end
  end

  lsgc_ram #(
    .WIDTH (lsgc_pkg::ENTRY_W),
    .DEPTH (AZIMUTH_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_bin_r};
  assign out_tuser  = out_cls_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !item_r)
    else $error("input ready while a point is still in work");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second point taken right after a transfer");

  a_drop_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lsgc_pkg::CLS_DROP |-> out_tdata == 16'd0)
    else $error("dropped point reports a nonzero bin");

  a_mark_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_wdata[48] |-> state_r == lsgc_pkg::ST_FIN && !out_tvalid_r ||
                                state_r == lsgc_pkg::ST_FIN && out_tready)
    else $error("ground mark written outside result hand-off");

endmodule

// ===== tb/sv/lidar_slope_ground_classifier_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_slope_ground_classifier_test
// Drives lidar points through the slope ground classifier and checks every
// result against a predictor kept in step with the block: crop windows, ring
// limit, azimuth binning, global ground level and the per-bin slope and
// noise-floor tests. Runs directed corner points and scan-like frames with
// random content mixed with raw noise, over several register settings, with
// random idling on both streams.
// ----------------------------------------------------------------------------
module lidar_slope_ground_classifier_test;
  import lsgc_pkg::*;

  localparam int  CLK_HALF     = 10;
  localparam int  RESET_CYCLES = 12;
  localparam int  PHASES       = 8;
  localparam int  PHASE_POINTS = 100;
  localparam int  CYCLE_LIMIT  = 4_000_000;
  localparam logic [31:0] WIN_ALL  = 32'h8000_7FFF;
  localparam logic [31:0] WIN_NONE = 32'h7FFF_8000;

  typedef struct packed {
    logic               frame_start;
    logic [15:0]        azimuth;
    logic [7:0]         ring;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef struct {
    cls_t       cls;
    logic [9:0] bin;
  } label_t;

  typedef logic [6:0][31:0] reg_set_t;

  // Tracks the register file and the per-bin ground points, and queues the
  // label each accepted point must come back with.
  class ground_label_model;
    logic [31:0]        regs [7];
    bit                 has_ground [AZIMUTH_BINS_DEF];
    logic signed [15:0] gx [AZIMUTH_BINS_DEF];
    logic signed [15:0] gy [AZIMUTH_BINS_DEF];
    logic signed [15:0] gz [AZIMUTH_BINS_DEF];
    label_t             labels_due [$];
    int                 fails;

    function new();
      regs[REG_FRONT_X]  = FRONT_X_RST;
      regs[REG_REAR_X]   = REAR_X_RST;
      regs[REG_LAT_Y]    = LAT_Y_RST;
      regs[REG_HEIGHT_Z] = HEIGHT_Z_RST;
      regs[REG_GROUND]   = GROUND_RST;
      regs[REG_STEP]     = STEP_RST;
      regs[REG_SLOPE]    = {8'h00, SLOPE_RST};
      foreach (has_ground[i]) has_ground[i] = 1'b0;
      fails = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      regs[idx] = (idx == REG_SLOPE) ? {8'h00, v[23:0]} : v;
    endfunction

    function bit in_win(logic [31:0] w, logic signed [15:0] v);
      return v >= $signed(w[31:16]) && v <= $signed(w[15:0]);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note_point(point_t p);
      label_t              lb;
      longint              dx, dy, dz, height, tol, obstacle, noise;
      longint unsigned     dxy2, dz2;
      int                  b;
      bit                  gnd;
      if (p.frame_start) begin
        foreach (has_ground[i]) has_ground[i] = 1'b0;
      end
      lb.cls = CLS_DROP;
      lb.bin = '0;
      if (in_win(regs[REG_LAT_Y], p.y) && in_win(regs[REG_HEIGHT_Z], p.z) &&
          (in_win(regs[REG_FRONT_X], p.x) || in_win(regs[REG_REAR_X], p.x)) &&
          int'(p.ring) < RING_COUNT_DEF) begin
        b = (int'(p.azimuth) * AZIMUTH_BINS_DEF) >> 16;
        if (b > AZIMUTH_BINS_DEF - 1) b = AZIMUTH_BINS_DEF - 1;
        height = longint'(regs[REG_GROUND][31:16]);
        tol    = longint'(regs[REG_GROUND][15:0]);
        gnd    = 1'b0;
        if (mag(longint'(p.z) + height) < tol) begin
          gnd = 1'b1;
        end else if (has_ground[b]) begin
          dx       = longint'(p.x) - longint'(gx[b]);
          dy       = longint'(p.y) - longint'(gy[b]);
          dz       = mag(longint'(p.z) - longint'(gz[b]));
          dxy2     = dx * dx + dy * dy;
          dz2      = dz * dz;
          obstacle = longint'(regs[REG_STEP][31:16]);
          noise    = longint'(regs[REG_STEP][15:0]);
          if ((dz2 << 16) < dxy2 * longint'(regs[REG_SLOPE][23:0]))
            gnd = 1'b1;
          else if (dz > obstacle)
            gnd = 1'b0;
          else if (dz < noise && dxy2 > MIN_PLANAR_SQ)
            gnd = 1'b1;
        end
        if (gnd) begin
          gx[b] = p.x;
          gy[b] = p.y;
          gz[b] = p.z;
          has_ground[b] = 1'b1;
        end
        lb.cls = gnd ? CLS_GROUND : CLS_NONGROUND;
        lb.bin = b[9:0];
      end
      labels_due.insert(labels_due.size(), lb);
    endfunction

    function void check_label(logic [1:0] cls, logic [9:0] bin);
      label_t lb;
      if (labels_due.size() == 0) begin
        $error("result with no point pending: class %0d, bin %0d", cls, bin);
        fails++;
        return;
      end
      lb = labels_due.pop_front();
      if (cls !== lb.cls) begin
        $error("point_class: expected %0d, actual %0d", lb.cls, cls);
        fails++;
      end
      if (bin !== lb.bin) begin
        $error("bin_index: expected %0d, actual %0d", lb.bin, bin);
        fails++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata    = '0;  // x_mm, y_mm, z_mm, ring_index, azimuth
  logic [0:0]  in_tuser    = '0;  // frame_start
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // bin_index, zero fill
  logic [1:0]  out_tuser;         // point_class
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr  = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ground_label_model labels = new();
  bit                calm = 1'b0;
  int                points_sent = 0;
  int                cycles = 0;

  lidar_slope_ground_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) labels.check_label(out_tuser, out_tdata[9:0]);
  end

  // Result-side back pressure in random bursts.
  initial begin : result_stalls
    int stall;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pair16(int upper, int lower);
    return {upper[15:0], lower[15:0]};
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int pick_in(logic [31:0] w);
    int lo, hi;
    lo = $signed(w[31:16]);
    hi = $signed(w[15:0]);
    if (lo <= hi) return lo + int'($urandom_range(0, hi - lo));
    return $signed(16'($urandom));
  endfunction

  // A value on or just past one of the window bounds.
  function automatic int window_edge(logic [31:0] w);
    int lo, hi;
    lo = $signed(w[31:16]);
    hi = $signed(w[15:0]);
    case ($urandom_range(0, 3))
      0: return lo - 1;
      1: return lo;
      2: return hi;
      default: return hi + 1;
    endcase
  endfunction

  function automatic point_t point_at(bit fs, int x, int y, int z, int ring, int az);
    point_t p;
    p.frame_start = fs;
    p.x           = sat16(x);
    p.y           = sat16(y);
    p.z           = sat16(z);
    p.ring        = ring[7:0];
    p.azimuth     = az[15:0];
    return p;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.frame_start = ($urandom_range(0, 15) == 0);
    p.x           = 16'($urandom);
    p.y           = 16'($urandom);
    p.z           = 16'($urandom);
    p.ring        = 8'($urandom);
    p.azimuth     = 16'($urandom);
    return p;
  endfunction

  function automatic reg_set_t phase_setting(int ph);
    case (ph)
      1: return {32'hA500_07F6, pair16(300, 100), pair16(1500, 100),
                 WIN_ALL, WIN_ALL, WIN_NONE, WIN_ALL};
      2: return {32'd5000, pair16(250, 80), pair16(1800, 60), pair16(-3000, 3000),
                 pair16(-8000, 8000), pair16(-20000, -500), pair16(500, 20000)};
      3: return {32'd0, 32'd0, 32'd0, WIN_ALL, WIN_ALL, WIN_ALL, WIN_ALL};
      4: return {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WIN_ALL, WIN_ALL,
                 pair16(0, 32767), pair16(-32768, 0)};
      5: return {32'd65536, pair16(500, 200), pair16(1000, 300), WIN_ALL,
                 pair16(-1000, 1000), pair16(0, 0), pair16(1, 0)};
      6: return {32'd65536, pair16(2000, 500), pair16(1200, 20), pair16(-4000, 1000),
                 pair16(-15000, 15000), pair16(-30000, -1), pair16(0, 30000)};
      default: return {32'd1000, pair16(150, 120), pair16(1700, 40), pair16(-2500, 2500),
                       pair16(-20000, 20000), pair16(200, 30000), pair16(-30000, -200)};
    endcase
  endfunction

  task automatic pause_input(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= {8'($urandom), $urandom, $urandom};
    in_tuser  <= 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_point(input point_t p);
    if (!calm && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 13));
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {p.azimuth, p.ring, p.z, p.y, p.x};
    in_tuser  <= p.frame_start;
    do @(posedge clk); while (!in_tready);
    labels.note_point(p);
    points_sent++;
  endtask

  task automatic apb_xfer(input bit wr, input reg_idx_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== labels.regs[idx]) begin
      $error("register %s: expected %h, actual %h", idx.name(), labels.regs[idx], rd);
      labels.fails++;
    end
  endtask

  task automatic program_reg(input reg_idx_t idx, input logic [31:0] v);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, v, rd);
    labels.set_reg(idx, v);
    check_reg(idx);
  endtask

  // Drop valid and wait until every queued label has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (labels.labels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Corner points under the phase 1 setting: sensor height 1500, tolerance
  // 100, obstacle 300, noise floor 100.
  task automatic run_directed();
    send_point(point_at(1, 1000, 0, -1500, 63, 0));          // global ground
    send_point(point_at(0, 5000, 0, -1380, 63, 10));         // slope test passes
    send_point(point_at(0, 5000, 0, -1380, 62, 20));         // same point again
    send_point(point_at(0, 5060, 0, -1330, 62, 30));         // noise floor passes
    send_point(point_at(0, 5100, 0, -900, 61, 40));          // obstacle step
    send_point(point_at(0, 5100, 0, -1250, 61, 50));         // too close in plane
    send_point(point_at(0, 0, 0, -1500, 64, 100));           // ring just too high
    send_point(point_at(0, 0, 0, -1500, 255, 100));
    send_point(point_at(0, -32768, -32768, -32768, 0, 65535));
    send_point(point_at(0, 32767, 32767, 32767, 63, 65535));
    send_point(point_at(0, 32767, -32768, -1499, 5, 64));
    send_point(point_at(0, -32768, 32767, -1400, 5, 127));
    send_point(point_at(1, 3000, 0, -1380, 60, 0));          // marks cleared
    send_point(point_at(0, 3000, 0, -1499, 60, 5));
    send_point(point_at(1, 0, 0, -1600, 1, 1000));           // tolerance bound
    send_point(point_at(0, 0, 0, -1401, 1, 1000));
  endtask

  // One frame of rings swept over the same azimuth span, so bins are
  // revisited with ground points that drift slowly and some obstacles.
  task automatic scan_frame();
    int          ring, rings, az, az0, x0, y0, ys, reach, zoff, height, zv;
    logic [31:0] xwin;
    point_t      p;
    bit          first;
    height = labels.regs[REG_GROUND][31:16];
    ring   = $urandom_range(40, 72);
    rings  = $urandom_range(3, 8);
    az0    = $urandom_range(0, 63000);
    xwin   = $urandom_range(0, 1) ? labels.regs[REG_FRONT_X] : labels.regs[REG_REAR_X];
    x0     = pick_in(xwin);
    y0     = pick_in(labels.regs[REG_LAT_Y]);
    reach  = 0;
    zoff   = int'($urandom_range(0, 60)) - 30;
    first  = ($urandom_range(0, 3) != 0);
    repeat (rings) begin
      az    = az0;
      ys    = y0;
      reach += $urandom_range(0, 1500);
      repeat ($urandom_range(4, 10)) begin
        zoff += int'($urandom_range(0, 80)) - 40;
        zv = zoff - height;
        if ($urandom_range(0, 6) == 0) zv += $urandom_range(100, 2500);
        p = point_at(first, x0 + (x0 < 0 ? -reach : reach), ys, zv, ring, az);
        first = 1'b0;
        case ($urandom_range(0, 23))
          0: p.x = sat16(window_edge(xwin));
          1: p.y = sat16(window_edge(labels.regs[REG_LAT_Y]));
          2: p.z = sat16(window_edge(labels.regs[REG_HEIGHT_Z]));
          3, 4: begin
            p = rand_point();
            p.frame_start = 1'b0;
          end
          default: ;
        endcase
        send_point(p);
        az += $urandom_range(8, 200);
        ys += int'($urandom_range(0, 400)) - 100;
      end
      ring -= $urandom_range(1, 3);
      if (ring < 0) break;
    end
  endtask

  initial begin : stimulus
    reg_set_t plan;
    int       goal;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 7; i++) check_reg(reg_idx_t'(i));
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        calm = (ph >= PHASES - 2);
        plan = phase_setting(ph);
        for (int i = 0; i < 7; i++) program_reg(reg_idx_t'(i), plan[i]);
      end
      if (ph == 1) run_directed();
      goal = points_sent + PHASE_POINTS;
      while (points_sent < goal) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 6)) send_point(rand_point());
        else
          scan_frame();
      end
    end
    settle();
    if (labels.fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
